[rtl/oets_pkg.sv]
// oets_pkg: shared types and constants for the odd-even transposition sorter
// no dependencies; imported by the controller, datapath and top level

package oets_pkg;

  // width of one list element
  localparam int unsigned DATA_W = 32;

  // controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // push the incoming value in at the bottom of the row
    logic sort;   // run one compare-exchange phase
    logic odd;    // phase parity: pairs (1,2),(3,4),... when set
    logic shift;  // drop the bottom element after an output transfer
  } dp_cmd_t;

endpackage : oets_pkg

[rtl/oets_ctrl.sv]
// oets_ctrl: state machine for load, sort phases and emit of one list
// depends on oets_pkg (state_t, dp_cmd_t)

module oets_ctrl #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  is_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  end_of_list,
  output oets_pkg::dp_cmd_t                     cmd,
  output logic [$clog2(MAX_ITEMS + 1) - 1:0]    count
);
  import oets_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  state_t          state;
  state_t          state_next;
  logic [CW - 1:0] count_next;
  logic [CW - 1:0] phase;
  logic [CW - 1:0] phase_next;
  logic            in_xfer;
  logic            out_xfer;
  logic            room;
  logic            last_phase;

  assign in_xfer    = in_valid && (state == ST_LOAD);
  assign out_xfer   = (state == ST_EMIT) && !out_stall;
  assign room       = count < CW'(MAX_ITEMS);
  assign last_phase = phase == (count - CW'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_valid && is_last) state_next = ST_SORT;
      end
      ST_SORT: begin
        if (last_phase) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer && (count == CW'(1))) state_next = ST_LOAD;
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    end_of_list = 1'b0;
    cmd         = '0;
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_xfer && room;
      end
      ST_SORT: begin
        cmd.sort = 1'b1;
        cmd.odd  = phase[0];
      end
      ST_EMIT: begin
        out_valid   = 1'b1;
        end_of_list = count == CW'(1);
        cmd.shift   = out_xfer;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // element count and phase counter
  always_comb begin
    count_next = count;
    phase_next = phase;
    if (cmd.load) count_next = count + CW'(1);
    if (state == ST_SORT) phase_next = last_phase ? '0 : phase + CW'(1);
    if (out_xfer) count_next = count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      phase <= phase_next;
    end
  end

endmodule : oets_ctrl

[rtl/oets_dp.sv]
// oets_dp: row of element registers with a compare-exchange network
// depends on oets_pkg (DATA_W, dp_cmd_t)

module oets_dp #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic                                  clk,
  input  oets_pkg::dp_cmd_t                     cmd,
  input  logic [$clog2(MAX_ITEMS + 1) - 1:0]    count,
  input  logic signed [oets_pkg::DATA_W - 1:0]  value,
  output logic signed [oets_pkg::DATA_W - 1:0]  sorted_value
);
  import oets_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic signed [DATA_W - 1:0] store      [MAX_ITEMS];
  logic signed [DATA_W - 1:0] store_next [MAX_ITEMS];

  // load pushes up, a phase swaps out-of-order disjoint pairs, emit shifts down
  always_comb begin
    for (int k = 0; k < MAX_ITEMS; k++) begin
      store_next[k] = store[k];
    end
    if (cmd.load) begin
      store_next[0] = value;
      for (int k = 1; k < MAX_ITEMS; k++) begin
        store_next[k] = store[k - 1];
      end
    end else if (cmd.sort) begin
      for (int k = 0; k + 1 < MAX_ITEMS; k++) begin
        if ((((k & 1) != 0) == cmd.odd) && (CW'(k + 1) < count)
            && (store[k] > store[k + 1])) begin
          store_next[k]     = store[k + 1];
          store_next[k + 1] = store[k];
        end
      end
    end else if (cmd.shift) begin
      for (int k = 0; k + 1 < MAX_ITEMS; k++) begin
        store_next[k] = store[k + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_ITEMS; k++) begin
      store[k] <= store_next[k];
    end
  end

  // once sorted, the smallest remaining element sits at the bottom
  assign sorted_value = store[0];

endmodule : oets_dp

[rtl/odd_even_transposition_sort.sv]
// odd_even_transposition_sort: top level joining controller and datapath
// depends on oets_pkg, oets_ctrl, oets_dp
//
// Usage:
//   Input channel (in_valid, in_stall, value, is_last) carries one list
//   element per transfer. Up to MAX_ITEMS elements are held; further ones
//   are dropped but their is_last flag still acts. A transfer with is_last
//   set closes the list and starts the sort.
//   Sorting runs n compare-exchange phases, one per cycle, each across all
//   pairs of one parity at once (n = elements held). The output channel
//   (out_valid, out_stall, sorted_value, end_of_list) then presents the n
//   elements in ascending order, one per cycle when not stalled, with
//   end_of_list on the final one.
//   The first result is valid once the last sort phase has run.
//   in_stall is high after the final input transfer until the last result
//   has been taken, so one list is in flight at a time.
//   A stall on the output holds the current result and the whole block.
//   Synchronous reset empties the list and returns to loading; element
//   registers are not cleared.

module odd_even_transposition_sort #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [oets_pkg::DATA_W - 1:0]  value,
  input  logic                                  is_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [oets_pkg::DATA_W - 1:0]  sorted_value,
  output logic                                  end_of_list
);
  import oets_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  dp_cmd_t         cmd;
  logic [CW - 1:0] count;

  // sequencing of load, sort and emit
  oets_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .end_of_list (end_of_list),
    .cmd         (cmd),
    .count       (count)
  );

  // element row and exchange network
  oets_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .count        (count),
    .value        (value),
    .sorted_value (sorted_value)
  );

endmodule : odd_even_transposition_sort

[rtl/oets_chk.sv]
// oets_chk: port-level checks on the sorter's output ordering and flow
// depends on oets_pkg; bound to odd_even_transposition_sort below

module oets_chk (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic signed [oets_pkg::DATA_W - 1:0]  value,
  input logic                                  is_last,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [oets_pkg::DATA_W - 1:0]  sorted_value,
  input logic                                  end_of_list
);
  import oets_pkg::*;

  // stalled input transfer holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(value) && $stable(is_last)))
    else $error("stalled input changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sorted_value)
                                  && $stable(end_of_list)))
    else $error("stalled result changed");

  // no input transfer while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while emitting");

  // results come out in ascending order
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !end_of_list)
      |=> (out_valid && (sorted_value >= $past(sorted_value))))
    else $error("results out of order");

  // list ends cleanly and loading resumes
  a_end_of_list: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && end_of_list) |=> (!out_valid && !in_stall))
    else $error("output continued past end of list");

endmodule : oets_chk

bind odd_even_transposition_sort oets_chk u_oets_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .value        (value),
  .is_last      (is_last),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .sorted_value (sorted_value),
  .end_of_list  (end_of_list)
);
